@@ sv/cpra_pkg.sv @@
// ----------------------------------------------------------------------------
// cpra_pkg
// Shared widths and codes for the contiguous page run allocator.
// ----------------------------------------------------------------------------
package cpra_pkg;

  // port field widths
  localparam int OPCODE_W = 1;
  localparam int SLOT_W   = 5;
  localparam int PAGE_W   = 16;
  localparam int RUN_W    = 6;
  localparam int POOL_W   = 6;
  localparam int STATUS_W = 2;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_RUN    = 2'd2;

endpackage

@@ sv/cpra_mem.sv @@
// ----------------------------------------------------------------------------
// cpra_mem
// Free page list storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cpra_mem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cpra_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpra_ctrl
// Sequencer for the allocator: list loads, first-fit scan over the list
// memory, shift of the entries in front of the run, and the result register.
// ----------------------------------------------------------------------------
module cpra_ctrl #(
  parameter int LIST_DEPTH = 32,
  parameter int PAGE_BITS  = 16,
  localparam int AW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cpra_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [cpra_pkg::SLOT_W-1:0]   slot_i,
  input  logic [cpra_pkg::PAGE_W-1:0]   page_i,
  input  logic [cpra_pkg::RUN_W-1:0]    run_length_i,
  // configuration
  input  logic [cpra_pkg::POOL_W-1:0]   pool_size_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cpra_pkg::STATUS_W-1:0] status_o,
  output logic [cpra_pkg::PAGE_W-1:0]   start_page_o,
  // list memory
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [PAGE_BITS-1:0]          mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [PAGE_BITS-1:0]          mem_rdata_i
);

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int RW    = cpra_pkg::RUN_W;
  localparam int SW    = cpra_pkg::STATUS_W;
  localparam int PW    = cpra_pkg::PAGE_W;
  localparam int CMP_W = (CNT_W > RW) ? CNT_W : RW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // control state
  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] consumed_q, consumed_d;
  logic             out_valid_q, out_valid_d;
  logic             pend_q, pend_d;
  logic             have_prev_q, have_prev_d;
  logic             wr_pend_q, wr_pend_d;
  logic [CNT_W-1:0] sh_left_q, sh_left_d;

  // working payload
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]     pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0]     matched_q, matched_d;
  logic [PAGE_BITS-1:0] prev_q, prev_d;
  logic [RW-1:0]        n_q, n_d;
  logic [CNT_W-1:0]     sh_src_q, sh_src_d;
  logic [AW-1:0]        wr_addr_q, wr_addr_d;
  logic [SW-1:0]        res_status_q, res_status_d;
  logic [PW-1:0]        res_start_q, res_start_d;
  logic [SW-1:0]        status_q, status_d;
  logic [PW-1:0]        start_q, start_d;

  logic                 out_free;
  logic                 in_acc;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     n_cnt;
  logic                 link;
  logic [CNT_W-1:0]     matched_nx;
  logic                 hit;
  logic [PAGE_BITS-1:0] run_first;
  logic [CNT_W-1:0]     dest_full;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // effective list size, clipped to the memory depth
  assign limit = (int'(pool_size_i) > LIST_DEPTH) ? CNT_W'(LIST_DEPTH)
                                                  : CNT_W'(pool_size_i);

  // run tracking on the word returned by the memory
  assign n_cnt      = CNT_W'(n_q);
  assign link       = have_prev_q &&
                      (({1'b0, prev_q} + {{PAGE_BITS{1'b0}}, 1'b1}) == {1'b0, mem_rdata_i});
  assign matched_nx = link ? (matched_q + CNT_W'(1)) : CNT_W'(1);
  assign hit        = pend_q && (CMP_W'(matched_nx) >= CMP_W'(n_q));
  assign run_first  = mem_rdata_i - PAGE_BITS'(n_q) + PAGE_BITS'(1);
  assign dest_full  = sh_src_q + n_cnt;

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    consumed_d   = consumed_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    have_prev_d  = have_prev_q;
    wr_pend_d    = wr_pend_q;
    sh_left_d    = sh_left_q;
    rd_idx_d     = rd_idx_q;
    pend_idx_d   = pend_idx_q;
    matched_d    = matched_q;
    prev_d       = prev_q;
    n_d          = n_q;
    sh_src_d     = sh_src_q;
    wr_addr_d    = wr_addr_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    status_d     = status_q;
    start_d      = start_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = AW'(slot_i);
    mem_wdata_o  = PAGE_BITS'(page_i);
    mem_raddr_o  = rd_idx_q[AW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (opcode_i == cpra_pkg::OP_LOAD) begin
            mem_we_o    = int'(slot_i) < LIST_DEPTH;
            out_valid_d = 1'b1;
            status_d    = cpra_pkg::ST_LOADED;
            start_d     = '0;
          end else begin
            n_d = run_length_i;
            if (run_length_i == '0) begin
              res_status_d = cpra_pkg::ST_NO_RUN;
              res_start_d  = '0;
              state_d      = S_DONE;
            end else begin
              rd_idx_d    = consumed_q;
              pend_d      = 1'b0;
              have_prev_d = 1'b0;
              matched_d   = '0;
              state_d     = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (pend_q) begin
          matched_d   = matched_nx;
          prev_d      = mem_rdata_i;
          have_prev_d = 1'b1;
        end
        if (hit) begin
          // run ends at pend_idx: move the entries in front of it up by n
          res_status_d = cpra_pkg::ST_ALLOCATED;
          res_start_d  = PW'(run_first);
          sh_src_d     = pend_idx_q - n_cnt;
          sh_left_d    = pend_idx_q + CNT_W'(1) - consumed_q - n_cnt;
          consumed_d   = consumed_q + n_cnt;
          wr_pend_d    = 1'b0;
          pend_d       = 1'b0;
          state_d      = S_SHIFT;
        end else if (rd_idx_q >= limit) begin
          res_status_d = cpra_pkg::ST_NO_RUN;
          res_start_d  = '0;
          pend_d       = 1'b0;
          state_d      = S_DONE;
        end else begin
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q;
          rd_idx_d   = rd_idx_q + CNT_W'(1);
        end
      end

      S_SHIFT: begin
        // write back the word read in the previous cycle
        if (wr_pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wr_addr_q;
          mem_wdata_o = mem_rdata_i;
        end
        if (sh_left_q != '0) begin
          mem_raddr_o = sh_src_q[AW-1:0];
          wr_pend_d   = 1'b1;
          wr_addr_d   = dest_full[AW-1:0];
          sh_src_d    = sh_src_q - CNT_W'(1);
          sh_left_d   = sh_left_q - CNT_W'(1);
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          start_d     = res_start_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      consumed_q  <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      have_prev_q <= 1'b0;
      wr_pend_q   <= 1'b0;
      sh_left_q   <= '0;
    end else begin
      state_q     <= state_d;
      consumed_q  <= consumed_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      have_prev_q <= have_prev_d;
      wr_pend_q   <= wr_pend_d;
      sh_left_q   <= sh_left_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    pend_idx_q   <= pend_idx_d;
    matched_q    <= matched_d;
    prev_q       <= prev_d;
    n_q          <= n_d;
    sh_src_q     <= sh_src_d;
    wr_addr_q    <= wr_addr_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    status_q     <= status_d;
    start_q      <= start_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign start_page_o = start_q;

endmodule

@@ sv/contiguous_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// contiguous_page_run_allocator
// First-fit allocator of runs of consecutive free pages from an ascending list.
// ----------------------------------------------------------------------------
// load: the result word is registered in the cycle after the input word is taken.
// allocate: first-fit scan of the list from the consumed count, then the entries in
//   front of the run are moved up by its length (one per cycle each); with no run
//   found, the result is ST_NO_RUN.
// one word is worked on at a time; the next is taken once the result is out.
// reset clears pool_size and the consumed count; list contents stay undefined.
module contiguous_page_run_allocator #(
  parameter int LIST_DEPTH = 32,
  parameter int PAGE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [cpra_pkg::POOL_W-1:0]   cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cpra_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [cpra_pkg::SLOT_W-1:0]   slot_i,
  input  logic [cpra_pkg::PAGE_W-1:0]   page_i,
  input  logic [cpra_pkg::RUN_W-1:0]    run_length_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cpra_pkg::STATUS_W-1:0] status_o,
  output logic [cpra_pkg::PAGE_W-1:0]   start_page_o
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [cpra_pkg::POOL_W-1:0] pool_size_q, pool_size_d;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [PAGE_BITS-1:0]        mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [PAGE_BITS-1:0]        mem_rdata;

  // pool size register
  assign pool_size_d = cfg_we_i ? cfg_data_i : pool_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= '0;
    end else begin
      pool_size_q <= pool_size_d;
    end
  end

  // sequencer
  cpra_ctrl #(
    .LIST_DEPTH (LIST_DEPTH),
    .PAGE_BITS  (PAGE_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .slot_i       (slot_i),
    .page_i       (page_i),
    .run_length_i (run_length_i),
    .pool_size_i  (pool_size_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .start_page_o (start_page_o),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // free page list
  cpra_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (PAGE_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
